### rtl/pda_pkg.sv
// shared constants and types for the pid deadband anti-windup controller
package pda_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_DEADBAND    = 3'd0,
      REG_KI_PERIOD   = 3'd1,
      REG_KP_DOWN     = 3'd2,
      REG_KD_DOWN     = 3'd3,
      REG_KP_UP       = 3'd4,
      REG_KD_UP       = 3'd5
   } reg_index_type;

   // clamp / saturation codes
   typedef enum logic [1:0] {
      CLAMP_NONE = 2'd0,
      CLAMP_HIGH = 2'd1,
      CLAMP_LOW  = 2'd2
   } clamp_type;

   localparam int POS_W   = 32;
   localparam int GAIN_W  = 24;
   localparam int DB_W    = 31;
   localparam int DRIVE_W = 17;
   localparam int CSR_W   = 32;
   localparam int FRAC_W  = 16;

   // effort limits in Q.16
   localparam logic signed [DRIVE_W-1:0] P_DOWN_LIMIT = -17'sd22938;
   localparam logic signed [DRIVE_W-1:0] U_HIGH_LIMIT = 17'sd58982;
   localparam logic signed [DRIVE_W-1:0] U_LOW_LIMIT  = -17'sd26214;

endpackage

### rtl/pid_deadband_antiwindup.sv
// pid position controller with deadband, anti-windup and direction-dependent gains
// an accepted word goes from the input register to the result register, driving rsp_
// throughput: one word per cycle while rsp_stall is low; the whole update sits
//    between the two registers, with three parallel gain multipliers in that path
// reset (synchronous, active high): gains, deadband, integral, history and
//    saturation state go to zero; both pipeline registers are emptied
module pid_deadband_antiwindup
   import pda_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // sample channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [POS_W-1:0]   req_target_pos,
   input  logic signed [POS_W-1:0]   req_measured_pos,
   input  logic                      req_first_sample,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [DRIVE_W-1:0] rsp_drive,
   output logic [1:0]                rsp_clamp_state,
   output logic                      rsp_in_deadband,
   // configuration write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [CSR_W-1:0]          csr_data
);

   // configuration registers
   logic [DB_W-1:0]   deadband_ff;
   logic [GAIN_W-1:0] ki_ff, kp_down_ff, kd_down_ff, kp_up_ff, kd_up_ff;

   // controller state
   logic signed [POS_W-1:0] last_target_ff, last_error_ff, integral_ff;
   logic [1:0]              sat_ff;

   // input register
   logic                    in_valid_ff;
   logic signed [POS_W-1:0] in_target_ff, in_measured_ff;
   logic                    in_first_ff;

   // result register
   logic                      out_valid_ff;
   logic signed [DRIVE_W-1:0] out_drive_ff;
   logic [1:0]                out_clamp_ff;
   logic                      out_db_ff;

   // handshake: the input word moves on when the result register is free
   logic advance, take_req;
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // error = target - measured, saturated to 32 bits
   logic signed [POS_W:0]   err_wide;
   logic signed [POS_W-1:0] err;
   assign err_wide = {in_target_ff[POS_W-1], in_target_ff}
                   - {in_measured_ff[POS_W-1], in_measured_ff};
   always_comb begin
      if (err_wide[POS_W] != err_wide[POS_W-1]) begin
         err = err_wide[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         err = err_wide[POS_W-1:0];
      end
   end

   // deadband: inside when -db < err < db
   logic signed [POS_W+1:0] err_x, db_pos, db_neg;
   logic                    inside_db;
   assign err_x     = {{2{err[POS_W-1]}}, err};
   assign db_pos    = {3'b000, deadband_ff};
   assign db_neg    = -db_pos;
   assign inside_db = (err_x < db_pos) && (err_x > db_neg);

   // moving down when measured is above target
   logic down;
   assign down = err[POS_W-1];

   logic [GAIN_W-1:0] kp_sel, kd_sel;
   assign kp_sel = down ? kp_down_ff : kp_up_ff;
   assign kd_sel = down ? kd_down_ff : kd_up_ff;

   // products, rounded to nearest with ties toward +inf, then >> 16
   localparam int PROD_W  = GAIN_W + 1 + POS_W;
   localparam int DPROD_W = GAIN_W + 1 + POS_W + 1;
   localparam logic signed [PROD_W-1:0]  HALF  = PROD_W'(1) <<< (FRAC_W - 1);
   localparam logic signed [DPROD_W-1:0] DHALF = DPROD_W'(1) <<< (FRAC_W - 1);

   logic signed [POS_W:0]     err_diff;
   logic signed [PROD_W-1:0]  prod_i, prod_p;
   logic signed [DPROD_W-1:0] prod_d;
   logic signed [PROD_W-1:0]  rnd_i, rnd_p;
   logic signed [DPROD_W-1:0] rnd_d;
   logic signed [PROD_W-FRAC_W-1:0]  incr, p_raw;
   logic signed [DPROD_W-FRAC_W-1:0] d_term;

   assign err_diff = {err[POS_W-1], err} - {last_error_ff[POS_W-1], last_error_ff};
   // the integral increment uses the stored previous error, not the current one
   assign prod_i = $signed({1'b0, ki_ff}) * last_error_ff;
   assign prod_p = $signed({1'b0, kp_sel}) * err;
   assign prod_d = $signed({1'b0, kd_sel}) * err_diff;
   assign rnd_i  = prod_i + HALF;
   assign rnd_p  = prod_p + HALF;
   assign rnd_d  = prod_d + DHALF;
   assign incr   = rnd_i[PROD_W-1:FRAC_W];
   assign p_raw  = rnd_p[PROD_W-1:FRAC_W];
   assign d_term = rnd_d[DPROD_W-1:FRAC_W];

   // integral with anti-windup hold, saturated to 32 bits
   localparam int ISUM_W = PROD_W - FRAC_W + 1;
   logic signed [ISUM_W-1:0] isum;
   logic signed [POS_W-1:0]  integ;
   logic                     hold_i;
   assign hold_i = (sat_ff == CLAMP_HIGH && incr > 0) || (sat_ff == CLAMP_LOW && incr < 0);
   assign isum   = ISUM_W'(integral_ff) + ISUM_W'(incr);
   always_comb begin
      if (hold_i) begin
         integ = integral_ff;
      end else if (isum > ISUM_W'(32'sh7fffffff)) begin
         integ = {1'b0, {(POS_W-1){1'b1}}};
      end else if (isum < -ISUM_W'(33'sh080000000)) begin
         integ = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         integ = isum[POS_W-1:0];
      end
   end

   // proportional clamp, one side per direction
   logic signed [DRIVE_W-1:0] p_term;
   always_comb begin
      if (down) begin
         p_term = (p_raw < P_DOWN_LIMIT) ? P_DOWN_LIMIT : p_raw[DRIVE_W-1:0];
      end else begin
         p_term = (p_raw >= U_HIGH_LIMIT) ? U_HIGH_LIMIT : p_raw[DRIVE_W-1:0];
      end
   end

   // sum and output clamp
   localparam int U_W = DPROD_W - FRAC_W + 2;
   logic signed [U_W-1:0]     u_sum;
   logic signed [DRIVE_W-1:0] drive;
   clamp_type                 clamp;
   assign u_sum = U_W'(p_term) + U_W'(integ) + U_W'(d_term);
   always_comb begin
      if (u_sum > U_W'(U_HIGH_LIMIT)) begin
         drive = U_HIGH_LIMIT;
         clamp = CLAMP_HIGH;
      end else if (u_sum < U_W'(U_LOW_LIMIT)) begin
         drive = U_LOW_LIMIT;
         clamp = CLAMP_LOW;
      end else begin
         drive = u_sum[DRIVE_W-1:0];
         clamp = CLAMP_NONE;
      end
   end

   // next integral: kept only unclamped, cleared on a new reference or first sample
   logic signed [POS_W-1:0] integral_in;
   always_comb begin
      if (in_first_ff || in_target_ff != last_target_ff) begin
         integral_in = '0;
      end else if (clamp == CLAMP_NONE) begin
         integral_in = integ;
      end else begin
         integral_in = integral_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff    <= '0;
         ki_ff          <= '0;
         kp_down_ff     <= '0;
         kd_down_ff     <= '0;
         kp_up_ff       <= '0;
         kd_up_ff       <= '0;
         last_target_ff <= '0;
         last_error_ff  <= '0;
         integral_ff    <= '0;
         sat_ff         <= CLAMP_NONE;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         // register writes, unknown indexes ignored
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DEADBAND:  deadband_ff <= csr_data[DB_W-1:0];
               REG_KI_PERIOD: ki_ff       <= csr_data[GAIN_W-1:0];
               REG_KP_DOWN:   kp_down_ff  <= csr_data[GAIN_W-1:0];
               REG_KD_DOWN:   kd_down_ff  <= csr_data[GAIN_W-1:0];
               REG_KP_UP:     kp_up_ff    <= csr_data[GAIN_W-1:0];
               REG_KD_UP:     kd_up_ff    <= csr_data[GAIN_W-1:0];
               default: ;
            endcase
         end

         // input register fills on accept, empties on advance
         if (take_req) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         // result register
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end

         // state moves only for samples outside the deadband
         if (advance && !inside_db) begin
            last_target_ff <= in_target_ff;
            last_error_ff  <= err;
            integral_ff    <= integral_in;
            sat_ff         <= clamp;
         end
      end

      // payload, no reset needed
      if (take_req) begin
         in_target_ff   <= req_target_pos;
         in_measured_ff <= req_measured_pos;
         in_first_ff    <= req_first_sample;
      end
      if (advance) begin
         out_drive_ff <= inside_db ? '0 : drive;
         out_clamp_ff <= inside_db ? CLAMP_NONE : clamp;
         out_db_ff    <= inside_db;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_drive       = out_drive_ff;
   assign rsp_clamp_state = out_clamp_ff;
   assign rsp_in_deadband = out_db_ff;

endmodule
